[hdl/bowc_pkg.sv]
// ---------------------------------------------------------------------------
// bowc_pkg
// types and fixed sizes shared by the weighted byte checksum block
// ---------------------------------------------------------------------------
package bowc_pkg;

    localparam int BYTE_W      = 8;
    localparam int SUM_W       = 32;
    localparam int TABLE_DEPTH = 1 << BYTE_W;

    typedef logic [BYTE_W-1:0]      byte_t;
    typedef logic [SUM_W-1:0]       weight_t;
    typedef logic [TABLE_DEPTH-1:0] valid_vec_t;

    // weight of a byte value at the start of a block: value plus one
    function automatic weight_t start_weight(input byte_t value);
        return weight_t'(value) + weight_t'(1);
    endfunction

endpackage

[hdl/byte_occurrence_weighted_checksum.sv]
// ---------------------------------------------------------------------------
// byte_occurrence_weighted_checksum
// per-block checksum that adds a per-value weight for each byte and then
// bumps that weight; the checksum is emitted on the block's last byte
// ---------------------------------------------------------------------------
// output: the checksum of a last item is registered into the output register
//   as the item leaves the update stage, which holds while a checksum waits on m_axis
// throughput: one item per cycle unless a checksum waits on m_axis; the weight
//   table RMW spans the registered read port and a one-entry write forward
// reset: sum and per-entry valid bits clear at once, no clearing pass; an
//   entry that is not valid reads as its start weight, and a last item clears
//   all valid bits in the cycle it leaves the update stage
module byte_occurrence_weighted_checksum
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] checksum
);

    // weight table memory
    bowc_pkg::weight_t mem [bowc_pkg::TABLE_DEPTH];
    bowc_pkg::weight_t rdata_reg;

    // update stage
    logic              s1_valid_reg, s1_valid_next;
    bowc_pkg::byte_t   s1_addr_reg;
    logic              s1_last_reg;

    // write forward toward the item right behind
    logic              fwd_valid_reg, fwd_valid_next;
    bowc_pkg::byte_t   fwd_addr_reg;
    bowc_pkg::weight_t fwd_data_reg;

    bowc_pkg::valid_vec_t valid_reg, valid_next;
    bowc_pkg::weight_t    sum_reg, sum_next;

    logic              out_valid_reg, out_valid_next;
    bowc_pkg::weight_t out_data_reg;

    logic              stall;
    logic              in_accept;
    logic              s1_fire;
    logic              mem_we;
    bowc_pkg::weight_t weight;
    bowc_pkg::weight_t sum_add;

    assign stall         = s1_valid_reg && s1_last_reg && out_valid_reg && !m_axis_tready;
    assign s_axis_tready = !stall;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s1_fire       = s1_valid_reg && !stall;
    assign mem_we        = s1_fire && !s1_last_reg;

    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            weight = fwd_data_reg;
        end
        else if (valid_reg[s1_addr_reg])
        begin
            weight = rdata_reg;
        end
        else
        begin
            weight = bowc_pkg::start_weight(s1_addr_reg);
        end
    end

    assign sum_add = sum_reg + weight;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        fwd_valid_next = fwd_valid_reg;
        valid_next     = valid_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (!stall)
        begin
            s1_valid_next  = in_accept;
            // forward only to an item whose read shares the edge of this write
            fwd_valid_next = mem_we && in_accept;
        end
        if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                valid_next     = '0;
                sum_next       = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                valid_next[s1_addr_reg] = 1'b1;
                sum_next                = sum_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            valid_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            valid_reg     <= valid_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_addr_reg <= s_axis_tdata;
            s1_last_reg <= s_axis_tlast;
        end
        if (mem_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= weight + bowc_pkg::weight_t'(1);
        end
        if (s1_fire && s1_last_reg)
        begin
            out_data_reg <= sum_add;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[s1_addr_reg] <= weight + bowc_pkg::weight_t'(1);
        end
        if (in_accept)
        begin
            rdata_reg <= mem[s_axis_tdata];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // a stall only comes from a finished checksum waiting behind a full output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && s1_valid_reg && s1_last_reg))
        else $error("input held off without a waiting checksum");

    // a forward entry always faces a live item in the update stage
    assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> s1_valid_reg)
        else $error("forward entry without an item to serve");

    // after a block closes the sum and the table start over
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> (sum_reg == '0 && valid_reg == '0 && m_axis_tvalid))
        else $error("block state not restored after last item");

    // an output item that is not taken holds its checksum
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output item changed while stalled");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench for byte_occurrence_weighted_checksum
// streams blocks of bytes into the checksum block with random idling on both
// sides, keeps its own copy of the per-value weights and the block sum, and
// compares every checksum that comes out against the oldest one predicted
// ---------------------------------------------------------------------------
module testbench;

    localparam int  CLK_HALF      = 10;
    localparam int  RANDOM_ITEMS  = 820;
    localparam int  CALM_TAIL     = 120;
    localparam int  LONG_LEN      = 64;
    localparam int  SETTLE_CYCLES = 4;
    localparam int  END_CYCLES    = 10;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed
    {
        bowc_pkg::byte_t data;
        logic            last;
        logic            drain;
        logic            quiet;
    } stream_item_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    // predictor state
    bowc_pkg::weight_t byte_weight [bowc_pkg::TABLE_DEPTH];
    bowc_pkg::weight_t block_sum;
    bowc_pkg::weight_t checksum_q [$];

    stream_item_t pending_items [$];
    stream_item_t next_item;

    logic   quiet_now   = 1'b1;
    bit     drain_wait  = 1'b0;
    int     settle_left = 0;
    int     send_gap    = 0;
    int     stall_left  = 0;

    int     error_count       = 0;
    longint bytes_accepted    = 0;
    int     blocks_closed     = 0;
    int     checksums_checked = 0;
    int     drains_done       = 0;
    longint cycle_count       = 0;

    byte_occurrence_weighted_checksum DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [31:0] checksum
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic void restore_weights();
        for (int v = 0; v < bowc_pkg::TABLE_DEPTH; v++)
            byte_weight[v] = bowc_pkg::weight_t'(v) + bowc_pkg::weight_t'(1);
        block_sum = '0;
    endfunction

    // count one byte into the block; a last byte closes the block
    function automatic void fold_byte(input bowc_pkg::byte_t value, input logic last);
        block_sum          = block_sum + byte_weight[value];
        byte_weight[value] = byte_weight[value] + bowc_pkg::weight_t'(1);
        if (last)
        begin
            checksum_q.push_back(block_sum);
            blocks_closed++;
            restore_weights();
        end
    endfunction

    task automatic add_byte(input bowc_pkg::byte_t value, input logic last,
                            input logic quiet);
        stream_item_t it;
        it.data  = value;
        it.last  = last;
        it.drain = 1'b0;
        it.quiet = quiet;
        pending_items.push_back(it);
    endtask

    task automatic add_drain();
        stream_item_t it;
        it       = '0;
        it.drain = 1'b1;
        it.quiet = 1'b1;
        pending_items.push_back(it);
    endtask

    function automatic bowc_pkg::byte_t pick_byte(input int mode,
                                                  input bowc_pkg::byte_t repeat_value);
        bowc_pkg::byte_t pool [4];
        pool[0] = 8'h00;
        pool[1] = 8'hFF;
        pool[2] = repeat_value;
        pool[3] = ~repeat_value;
        case (mode)
            0:       return bowc_pkg::byte_t'($urandom_range(0, 255));
            1:       return pool[$urandom_range(0, 3)];
            default: return repeat_value;
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
            quiet_now     <= 1'b1;
            send_gap    = 0;
            drain_wait  = 1'b0;
            settle_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                fold_byte(s_axis_tdata, s_axis_tlast);
                bytes_accepted++;
                if (!quiet_now && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 6);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (drain_wait)
                begin
                    s_axis_tvalid <= 1'b0;
                    if (checksum_q.size() == 0)
                    begin
                        if (settle_left == 0)
                        begin
                            drain_wait = 1'b0;
                            drains_done++;
                        end
                        else
                            settle_left--;
                    end
                end
                else if (pending_items.size() != 0)
                begin
                    next_item = pending_items.pop_front();
                    if (next_item.drain)
                    begin
                        drain_wait  = 1'b1;
                        settle_left = SETTLE_CYCLES;
                        s_axis_tvalid <= 1'b0;
                    end
                    else
                    begin
                        s_axis_tvalid <= 1'b1;
                        s_axis_tdata  <= next_item.data;
                        s_axis_tlast  <= next_item.last;
                        quiet_now     <= next_item.quiet;
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (checksum_q.size() == 0)
                begin
                    $error("checksum: no item expected, actual %08h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    bowc_pkg::weight_t want;
                    want = checksum_q.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        $error("checksum: expected %08h, actual %08h", want, m_axis_tdata);
                        error_count++;
                    end
                    checksums_checked++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet_now && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 6) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int              len;
        int              mode;
        int              random_bytes;
        bit              quiet;
        bowc_pkg::byte_t rep;

        restore_weights();

        // directed: one-byte blocks at both ends of the byte range
        add_byte(8'h00, 1'b1, 1'b1);
        add_byte(8'hFF, 1'b1, 1'b1);
        // repeated values raise their weights within one block
        add_byte(8'hFF, 1'b0, 1'b1);
        add_byte(8'hFF, 1'b0, 1'b1);
        add_byte(8'h00, 1'b0, 1'b1);
        add_byte(8'h00, 1'b0, 1'b1);
        add_byte(8'hFF, 1'b1, 1'b1);
        // same value in back-to-back blocks checks the table restore
        add_byte(8'h07, 1'b1, 1'b0);
        add_byte(8'h07, 1'b1, 1'b0);
        add_byte(8'h07, 1'b0, 1'b0);
        add_byte(8'h07, 1'b1, 1'b0);
        add_byte(8'h55, 1'b0, 1'b0);
        add_byte(8'hAA, 1'b0, 1'b0);
        add_byte(8'h55, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        add_byte(8'h01, 1'b1, 1'b0);
        add_byte(8'h01, 1'b0, 1'b0);
        add_byte(8'h02, 1'b0, 1'b0);
        add_byte(8'h04, 1'b0, 1'b0);
        add_byte(8'h7F, 1'b1, 1'b0);
        add_drain();

        // one long block of a single value keeps raising the same weight
        rep = bowc_pkg::byte_t'($urandom_range(0, 255));
        for (int n = 0; n < LONG_LEN; n++)
            add_byte(rep, (n == LONG_LEN - 1), 1'b0);
        add_drain();

        random_bytes = 0;
        while (random_bytes < RANDOM_ITEMS)
        begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64)
                                                 : $urandom_range(1, 12);
            quiet = (RANDOM_ITEMS - random_bytes < CALM_TAIL) ||
                    ($urandom_range(0, 4) == 0);
            mode  = $urandom_range(0, 2);
            rep   = bowc_pkg::byte_t'($urandom_range(0, 255));
            for (int i = 0; i < len; i++)
                add_byte(pick_byte(mode, rep), (i == len - 1), quiet);
            random_bytes += len;
            if (!quiet && $urandom_range(0, 19) == 0)
                add_drain();
        end
        // a few bytes with no closing mark must produce nothing
        for (int i = 0; i < 5; i++)
            add_byte(bowc_pkg::byte_t'($urandom_range(0, 255)), 1'b0, 1'b1);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || s_axis_tvalid || drain_wait)
            @(posedge clk);
        while (checksum_q.size() != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);

        $display("%0d bytes in %0d blocks, %0d checksums compared, %0d full drains",
                 bytes_accepted, blocks_closed, checksums_checked, drains_done);
        $display("covered one-byte blocks, repeated values, back-to-back blocks, unmarked tail");
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
